@@ sv/pswr_pkg.sv @@
// pswr_pkg: shared types, codes and phrase tables for the power state response watcher
// no dependencies; imported by power_state_response_watcher and tb_power_state_response_watcher
package pswr_pkg;

   // item kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_BYTE  = 2'd0,
      REQ_TICK  = 2'd1,
      REQ_START = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   // power status codes
   typedef enum logic [1:0] {
      ST_OFFLINE = 2'd0,
      ST_READY   = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   localparam int unsigned OFFLINE_LEN = 17;
   localparam int unsigned READY_LEN   = 10;
   localparam int unsigned OFF_IDX_W   = 5;
   localparam int unsigned RDY_IDX_W   = 4;
   localparam int unsigned TICK_W      = 16;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;

   typedef logic [OFF_IDX_W-1:0] off_idx_type;
   typedef logic [RDY_IDX_W-1:0] rdy_idx_type;
   typedef logic [TICK_W-1:0]    tick_type;

   // "NORMAL POWER DOWN"
   function automatic logic [7:0] offline_char(input off_idx_type idx);
      logic [7:0] c;
      unique case (idx)
         5'd0:    c = "N";
         5'd1:    c = "O";
         5'd2:    c = "R";
         5'd3:    c = "M";
         5'd4:    c = "A";
         5'd5:    c = "L";
         5'd6:    c = " ";
         5'd7:    c = "P";
         5'd8:    c = "O";
         5'd9:    c = "W";
         5'd10:   c = "E";
         5'd11:   c = "R";
         5'd12:   c = " ";
         5'd13:   c = "D";
         5'd14:   c = "O";
         5'd15:   c = "W";
         5'd16:   c = "N";
         default: c = "N";
      endcase
      return c;
   endfunction

   // "Call Ready"
   function automatic logic [7:0] ready_char(input rdy_idx_type idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = "C";
         4'd1:    c = "a";
         4'd2:    c = "l";
         4'd3:    c = "l";
         4'd4:    c = " ";
         4'd5:    c = "R";
         4'd6:    c = "e";
         4'd7:    c = "a";
         4'd8:    c = "d";
         4'd9:    c = "y";
         default: c = "C";
      endcase
      return c;
   endfunction

endpackage

@@ sv/power_state_response_watcher.sv @@
// power_state_response_watcher (uses pswr_pkg): rsp_tvalid follows the req transfer through the
// input register, then phrase match / timeout logic into the result register
// throughput one item per cycle; a stalled rsp side holds the input register
// synchronous active-high reset: status offline, watch disarmed, indexes and
// tick count cleared, timeout register back to 100; no clearing pass
// csr_ready is always high
module power_state_response_watcher (
   input  logic                   clock,
   input  logic                   reset,
   // config write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_data,    // timeout_ticks
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] rx_byte
   input  logic [1:0]             req_tuser,   // [1:0] req_type
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata    // [1:0] power_status, [2] watch_done,
                                               // [3] watching, [7:4] zero
);
   import pswr_pkg::*;

   // configuration register
   tick_type timeout_ff;

   // input register
   logic         in_vld_ff;
   logic [1:0]   in_kind_ff;
   logic [7:0]   in_byte_ff;

   // watcher state
   off_idx_type  off_prog_ff, off_prog_in;
   rdy_idx_type  rdy_prog_ff, rdy_prog_in;
   tick_type     ticks_ff, ticks_in;
   logic         armed_ff, armed_in;
   status_type   status_ff, status_in;
   logic         done_in;

   // result register
   logic         out_vld_ff;
   logic [7:0]   out_data_ff;

   logic         advance;

   assign csr_ready  = 1'b1;
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // timeout register write
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_data;
      end
   end

   // input register: load on request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // phrase match, tick count and start handling
   always_comb begin
      off_idx_type oi;
      rdy_idx_type ri;
      oi = (off_prog_ff < OFF_IDX_W'(OFFLINE_LEN)) ? off_prog_ff : '0;
      ri = (rdy_prog_ff < RDY_IDX_W'(READY_LEN)) ? rdy_prog_ff : '0;

      off_prog_in = off_prog_ff;
      rdy_prog_in = rdy_prog_ff;
      ticks_in    = ticks_ff;
      armed_in    = armed_ff;
      status_in   = status_ff;
      done_in     = 1'b0;

      unique case (req_kind_type'(in_kind_ff))
         REQ_START: begin
            off_prog_in = '0;
            rdy_prog_in = '0;
            if (timeout_ff == '0) begin
               status_in = ST_UNKNOWN;
               armed_in  = 1'b0;
               ticks_in  = '0;
               done_in   = 1'b1;
            end else begin
               ticks_in = timeout_ff;
               armed_in = 1'b1;
            end
         end
         REQ_TICK: begin
            if (armed_ff) begin
               ticks_in = ticks_ff - TICK_W'(1);
               if (ticks_in == '0) begin
                  status_in   = ST_UNKNOWN;
                  armed_in    = 1'b0;
                  off_prog_in = '0;
                  rdy_prog_in = '0;
                  done_in     = 1'b1;
               end
            end
         end
         REQ_BYTE: begin
            if (armed_ff) begin
               // offline phrase checked first
               priority if (in_byte_ff == offline_char(oi)) begin
                  off_prog_in = oi + OFF_IDX_W'(1);
                  rdy_prog_in = '0;
                  if (off_prog_in == OFF_IDX_W'(OFFLINE_LEN)) begin
                     status_in   = ST_OFFLINE;
                     armed_in    = 1'b0;
                     off_prog_in = '0;
                     ticks_in    = '0;
                     done_in     = 1'b1;
                  end
               end else if (in_byte_ff == ready_char(ri)) begin
                  rdy_prog_in = ri + RDY_IDX_W'(1);
                  off_prog_in = '0;
                  if (rdy_prog_in == RDY_IDX_W'(READY_LEN)) begin
                     status_in   = ST_READY;
                     armed_in    = 1'b0;
                     rdy_prog_in = '0;
                     ticks_in    = '0;
                     done_in     = 1'b1;
                  end
               end else begin
                  off_prog_in = '0;
                  rdy_prog_in = '0;
               end
            end
         end
         default: begin
            // unused code: no change
         end
      endcase
   end

   // watcher state update on each item leaving the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         off_prog_ff <= '0;
         rdy_prog_ff <= '0;
         ticks_ff    <= '0;
         armed_ff    <= 1'b0;
         status_ff   <= ST_OFFLINE;
      end else if (advance) begin
         off_prog_ff <= off_prog_in;
         rdy_prog_ff <= rdy_prog_in;
         ticks_ff    <= ticks_in;
         armed_ff    <= armed_in;
         status_ff   <= status_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
      if (advance) begin
         out_data_ff <= {4'b0000, armed_in, done_in, status_in};
      end
   end

   // an armed watch always has ticks remaining
   a_armed_ticks: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (ticks_ff != '0))
      else $error("armed watch with zero ticks left");

   // at most one phrase is in progress
   a_one_phrase: assert property (@(posedge clock) disable iff (reset)
      (off_prog_ff != '0) |-> (rdy_prog_ff == '0))
      else $error("both phrase indexes in progress");

   // no progress kept while disarmed
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (off_prog_ff == '0 && rdy_prog_ff == '0))
      else $error("phrase progress held while disarmed");

   // a transfer that ends the watch never reports it still armed
   a_done_disarmed: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_data_ff[2] |-> !out_data_ff[3])
      else $error("watch_done with watching set");

   // result register only refills from an advancing item
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready |=> out_vld_ff && $stable(out_data_ff))
      else $error("stalled result changed");

endmodule

@@ tb/sv/tb_power_state_response_watcher.sv @@
`timescale 1ns / 100ps
// tb_power_state_response_watcher: self-checking bench for the power state response watcher
// depends on pswr_pkg (item kinds, status codes, widths) and power_state_response_watcher
module tb_power_state_response_watcher;
   import pswr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 80;
   localparam logic [8*OFFLINE_LEN-1:0] OFFLINE_TEXT = "NORMAL POWER DOWN";
   localparam logic [8*READY_LEN-1:0]   READY_TEXT   = "Call Ready";

   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   rx_byte;
   } watch_item_type;

   typedef struct packed {
      status_type status;
      logic       done;
      logic       watching;
   } watch_status_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic [15:0] csr_data  = '0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;
   logic [1:0] req_tuser  = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   // items waiting to be sent and results still owed by the block
   watch_item_type   pending_items[$];
   watch_status_type owed_status[$];

   // shadow of the watcher state and its timeout register
   status_type  status_now   = ST_OFFLINE;
   off_idx_type offline_pos  = '0;
   rdy_idx_type ready_pos    = '0;
   tick_type    ticks_left   = '0;
   logic        armed        = 1'b0;
   tick_type    timeout_now  = TIMEOUT_RESET;

   int unsigned send_gap     = 0;
   int unsigned recv_stall   = 0;
   bit          quiet_mode   = 1'b0;
   int unsigned cycle_count  = 0;
   int unsigned failures     = 0;
   int unsigned queued_count = 0;
   int unsigned items_sent   = 0;
   int unsigned cfg_writes   = 0;
   int unsigned offline_hits = 0;
   int unsigned ready_hits   = 0;
   int unsigned timeout_ends = 0;

   power_state_response_watcher u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // character idx of the offline phrase or of the ready phrase
   function automatic logic [7:0] phrase_byte(input bit offline, input int idx);
      if (offline) return OFFLINE_TEXT[8*(OFFLINE_LEN-1-idx) +: 8];
      return READY_TEXT[8*(READY_LEN-1-idx) +: 8];
   endfunction

   function automatic void end_watch(input status_type final_status);
      status_now  = final_status;
      armed       = 1'b0;
      offline_pos = '0;
      ready_pos   = '0;
      ticks_left  = '0;
   endfunction

   // advance the shadow state by one item and return the status it reports
   function automatic watch_status_type step_watch(input watch_item_type it);
      watch_status_type r;
      int oi;
      int ri;
      logic done;
      done = 1'b0;
      unique case (it.kind)
         REQ_START: begin
            offline_pos = '0;
            ready_pos   = '0;
            if (timeout_now == 0) begin
               end_watch(ST_UNKNOWN);
               done = 1'b1;
            end else begin
               ticks_left = timeout_now;
               armed      = 1'b1;
            end
         end
         REQ_TICK: begin
            if (armed) begin
               ticks_left = ticks_left - 1'b1;
               if (ticks_left == 0) begin
                  end_watch(ST_UNKNOWN);
                  done = 1'b1;
               end
            end
         end
         REQ_BYTE: begin
            if (armed) begin
               oi = (offline_pos < OFFLINE_LEN) ? int'(offline_pos) : 0;
               ri = (ready_pos < READY_LEN) ? int'(ready_pos) : 0;
               // offline phrase has priority; advancing one phrase clears the other
               if (it.rx_byte == phrase_byte(1'b1, oi)) begin
                  offline_pos = off_idx_type'(oi + 1);
                  ready_pos   = '0;
                  if (offline_pos == OFFLINE_LEN) begin
                     end_watch(ST_OFFLINE);
                     done = 1'b1;
                  end
               end else if (it.rx_byte == phrase_byte(1'b0, ri)) begin
                  ready_pos   = rdy_idx_type'(ri + 1);
                  offline_pos = '0;
                  if (ready_pos == READY_LEN) begin
                     end_watch(ST_READY);
                     done = 1'b1;
                  end
               end else begin
                  offline_pos = '0;
                  ready_pos   = '0;
               end
            end
         end
         default: begin
         end
      endcase
      r.status   = status_now;
      r.done     = done;
      r.watching = armed;
      return r;
   endfunction

   // request driver: pops pending items, random gap after each transfer (none in quiet mode)
   always @(posedge clock) begin
      watch_item_type   next_item;
      watch_status_type owed;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            owed = step_watch('{req_kind_type'(req_tuser), req_tdata});
            owed_status.push_back(owed);
            items_sent++;
            if (owed.done) begin
               if (owed.status == ST_OFFLINE) offline_hits++;
               else if (owed.status == ST_READY) ready_hits++;
               else timeout_ends++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               req_tvalid <= 1'b0;
               send_gap   <= send_gap - 1;
            end else if (pending_items.size() != 0) begin
               next_item = pending_items.pop_front();
               req_tuser  <= next_item.kind;
               req_tdata  <= next_item.rx_byte;
               req_tvalid <= 1'b1;
               send_gap   <= quiet_mode ? 0 : $urandom_range(0, 7);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string field, input logic [3:0] want, input logic [3:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         failures++;
      end
   endtask

   // response monitor: checks each transfer, random stall after it (none in quiet mode)
   always @(posedge clock) begin
      watch_status_type want;
      int unsigned      stall_draw;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (owed_status.size() == 0) begin
            $error("rsp transfer with nothing owed: tdata %h", rsp_tdata);
            failures++;
         end else begin
            want = owed_status.pop_front();
            check_field("power_status", 4'(want.status), 4'(rsp_tdata[1:0]));
            check_field("watch_done", 4'(want.done), 4'(rsp_tdata[2]));
            check_field("watching", 4'(want.watching), 4'(rsp_tdata[3]));
            check_field("pad", 4'd0, rsp_tdata[7:4]);
         end
         stall_draw = quiet_mode ? 0 : $urandom_range(0, 7);
         recv_stall <= stall_draw;
         rsp_tready <= (stall_draw == 0);
      end else if (recv_stall > 1) begin
         recv_stall <= recv_stall - 1;
      end else begin
         recv_stall <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // timeout register shadow follows csr transfers
   always @(posedge clock) begin
      if (reset) begin
         timeout_now = TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_now = csr_data;
         cfg_writes++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_power_state_response_watcher failed");
         $finish;
      end
   end

   task automatic push_item(input req_kind_type kind, input logic [7:0] b);
      pending_items.push_back('{kind, b});
      if (kind != REQ_NONE) queued_count++;
   endtask

   // first upto characters of a phrase, with the odd tick mixed in when with_ticks is set
   task automatic push_phrase(input bit offline, input int upto, input bit with_ticks);
      for (int k = 0; k < upto; k++) begin
         if (with_ticks && $urandom_range(0, 7) == 0) push_item(REQ_TICK, 8'(k));
         push_item(REQ_BYTE, phrase_byte(offline, k));
      end
   endtask

   // random phase: mostly armed phrase attempts, the rest noise
   task automatic queue_phase(input int unsigned count);
      int unsigned goal;
      int unsigned pick;
      int unsigned len;
      int unsigned plen;
      bit which;
      bit other;
      goal = queued_count + count;
      while (queued_count < goal) begin
         pick  = $urandom_range(0, 9);
         which = $urandom_range(0, 1);
         plen  = which ? OFFLINE_LEN : READY_LEN;
         unique case (pick)
            0, 1, 2, 3: begin
               // start, a little phrase-alphabet noise, then a whole phrase
               push_item(REQ_START, 8'($urandom_range(0, 255)));
               len = $urandom_range(0, 2);
               for (int k = 0; k < len; k++) begin
                  other = $urandom_range(0, 1);
                  push_item(REQ_BYTE, phrase_byte(other,
                     $urandom_range(0, (other ? OFFLINE_LEN : READY_LEN) - 1)));
               end
               push_phrase(which, plen, 1'b1);
            end
            4, 5: begin
               // phrase broken by a random byte, then retried
               push_item(REQ_START, 8'h00);
               push_phrase(which, $urandom_range(1, plen - 1), 1'b0);
               push_item(REQ_BYTE, 8'($urandom_range(0, 255)));
               push_phrase(which, plen, 1'b1);
            end
            6: begin
               len = $urandom_range(1, 12);
               for (int k = 0; k < len; k++) push_item(REQ_TICK, 8'($urandom_range(0, 255)));
            end
            7: begin
               len = $urandom_range(1, 6);
               for (int k = 0; k < len; k++) push_item(REQ_BYTE, 8'($urandom_range(0, 255)));
            end
            8: begin
               len = $urandom_range(1, 4);
               for (int k = 0; k < len; k++)
                  push_item(req_kind_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            default: begin
               // prefix of one phrase, then the other phrase in full
               push_item(REQ_START, 8'hFF);
               push_phrase(which, $urandom_range(1, plen - 1), 1'b0);
               push_phrase(!which, which ? READY_LEN : OFFLINE_LEN, 1'b0);
            end
         endcase
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_tvalid || owed_status.size() != 0);
   endtask

   task automatic write_timeout(input tick_type value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   // stimulus: directed items, then random phases at several timeouts
   initial begin
      tick_type timeouts[7];
      timeouts = '{16'd1, 16'd65535, 16'd6, 16'd0, 16'd25,
                   tick_type'($urandom_range(2, 400)), 16'd3};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // not armed: bytes, ticks and code three change nothing
      push_item(REQ_BYTE, "N");
      push_item(REQ_TICK, 8'h00);
      push_item(REQ_NONE, 8'hA5);
      push_item(REQ_BYTE, 8'hFF);
      // armed at the reset timeout, ready phrase completes
      push_item(REQ_START, 8'h00);
      push_phrase(1'b0, READY_LEN, 1'b0);
      // non-ascii byte clears progress, code three while armed, restart while armed
      push_item(REQ_START, 8'h00);
      push_item(REQ_BYTE, "N");
      push_item(REQ_BYTE, 8'h80);
      push_item(REQ_NONE, 8'h7F);
      push_item(REQ_BYTE, "N");
      push_item(REQ_START, 8'h00);
      push_item(REQ_TICK, 8'h00);
      push_item(REQ_BYTE, 8'h00);
      wait_idle();

      // zero timeout ends the watch at once
      write_timeout(16'd0);
      push_item(REQ_START, 8'h00);
      push_item(REQ_BYTE, "C");
      wait_idle();

      foreach (timeouts[p]) begin
         write_timeout(timeouts[p]);
         quiet_mode = (p % 3 == 2);
         queue_phase(PHASE_ITEMS);
         wait_idle();
      end

      repeat (8) @(posedge clock);
      $display("sent %0d items over %0d timeout settings, random idling on both sides",
               items_sent, cfg_writes);
      $display("watch ends seen: %0d offline, %0d ready, %0d timeout",
               offline_hits, ready_hits, timeout_ends);
      if (failures == 0) begin
         $display("tb_power_state_response_watcher passed");
      end else begin
         $display("tb_power_state_response_watcher failed");
      end
      $finish;
   end

endmodule
